>>> rtl/npba_pkg.sv
// ----------------------------------------------------------------------------
// npba_pkg
// Shared types and constants of the translated port allocator: controller
// states, result status codes and the fixed port numbering.
// ----------------------------------------------------------------------------
package npba_pkg;

   // External port numbers are 16 bits wide; slot 0 stands for this port
   localparam int PORT_W    = 16;
   localparam int PORT_BASE = 1024;

   // Width of the used-slot counter
   localparam int COUNT_W = 16;

   // Width of the skip field on the request side
   localparam int SKIP_W = 5;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_FREE  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_NORM,
      S_SCAN,
      S_GRANT,
      S_DIV,
      S_FREE_CHK,
      S_FINISH
   } state_type;

   // Request operation selector
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

endpackage

>>> rtl/npba_bitmap_ram.sv
// ----------------------------------------------------------------------------
// npba_bitmap_ram
// Used/free bitmap store: one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module npba_bitmap_ram #(
   parameter int DEPTH  = 2016,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one word, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/npba_slot_split.sv
// ----------------------------------------------------------------------------
// npba_slot_split
// Splits a slot number into bitmap word and bit position with a reciprocal
// multiply: the quotient is registered in the cycle after start, the remainder
// in the cycle after that, when done is raised.
// ----------------------------------------------------------------------------
module npba_slot_split #(
   parameter int WORD_BITS = 32,
   parameter int BIT_W     = 5,
   parameter int ADDR_W    = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [npba_pkg::PORT_W-1:0]   slot,
   output logic                          done,
   output logic [ADDR_W-1:0]             word,
   output logic [BIT_W-1:0]              bit_pos
);

   localparam int SLOT_W  = npba_pkg::PORT_W;
   localparam int SHIFT   = SLOT_W + BIT_W;
   localparam int RECIP_W = SLOT_W + 1;
   localparam int PROD_W  = SHIFT + SLOT_W;
   // ceil(2^SHIFT / WORD_BITS); exact quotient for every slot of SLOT_W bits
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'(1) << SHIFT) + 64'(WORD_BITS - 1)) / 64'(WORD_BITS));

   logic              stage_ff, stage_in;
   logic              done_ff, done_in;
   logic [SLOT_W-1:0] dvd_ff, dvd_in;
   logic [SLOT_W-1:0] quo_ff, quo_in;
   logic [BIT_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] product;
   logic [SLOT_W-1:0] back;
   logic [SLOT_W-1:0] diff;

   // Quotient by reciprocal, then remainder from the registered quotient
   always_comb begin
      product  = PROD_W'(slot) * PROD_W'(RECIP);
      back     = SLOT_W'(quo_ff * SLOT_W'(WORD_BITS));
      diff     = dvd_ff - back;
      stage_in = start;
      done_in  = stage_ff;
      dvd_in   = start ? slot : dvd_ff;
      quo_in   = start ? product[SHIFT +: SLOT_W] : quo_ff;
      rem_in   = stage_ff ? diff[BIT_W-1:0] : rem_ff;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   // Hold datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done    = done_ff;
   assign word    = quo_ff[ADDR_W-1:0];
   assign bit_pos = rem_ff;

endmodule

>>> rtl/npba_free_finder.sv
// ----------------------------------------------------------------------------
// npba_free_finder
// Finds the lowest free slot in one bitmap word, starting at a given bit on
// the first word of a search and ignoring the unused tail of the last word.
// ----------------------------------------------------------------------------
module npba_free_finder #(
   parameter int WORD_BITS = 32,
   parameter int BIT_W     = 5,
   parameter int LAST_BITS = 32
) (
   input  logic [WORD_BITS-1:0] word_data,
   input  logic [BIT_W-1:0]     start_bit,
   input  logic                 first,
   input  logic                 last_word,
   output logic                 found,
   output logic [BIT_W-1:0]     index
);

   localparam logic [WORD_BITS-1:0] LAST_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

   logic [WORD_BITS-1:0] first_mask;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] avail;
   logic [WORD_BITS-1:0] lowest;

   // Mask off used bits, bits before the start and slots past the end
   always_comb begin
      first_mask = first ? ({WORD_BITS{1'b1}} << start_bit) : {WORD_BITS{1'b1}};
      valid_mask = last_word ? LAST_MASK : {WORD_BITS{1'b1}};
      avail      = ~word_data & first_mask & valid_mask;
      lowest     = avail & (~avail + WORD_BITS'(1));
      found      = |avail;
   end

   // Encode the isolated lowest free bit
   always_comb begin
      index = '0;
      for (int k = 0; k < BIT_W; k++) begin
         for (int i = 0; i < WORD_BITS; i++) begin
            index[k] = index[k] | (lowest[i] & 1'((i >> k) & 1));
         end
      end
   end

endmodule

>>> rtl/nat_port_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// nat_port_bitmap_allocator_top
// Translated port allocator over a used/free bitmap with a next-fit cursor.
//
// Each slot s stands for external port s + 1024; one bit per slot lives in a
// single bitmap RAM of WORD_BITS-wide words. After reset the block sweeps the
// RAM to zero, one word a cycle over ceil(SLOT_COUNT / WORD_BITS) words (2016
// at the defaults), and takes no request until the sweep ends. One request is
// worked at a time. An allocate advances the cursor by the saturated skip,
// wraps it back into range one word boundary a cycle, then reads and tests
// one bitmap word a cycle until a free bit turns up. An allocate with every
// slot taken answers full without touching the bitmap. A free splits the
// port into word and bit with a reciprocal multiply, then reads and tests
// the word, clears the bit if it was in use and else flags a bad free. The
// result sits in an output register, so the next request is taken while it
// waits.
// ----------------------------------------------------------------------------
module nat_port_bitmap_allocator_top #(
   parameter int SLOT_COUNT = 64512,
   parameter int WORD_BITS  = 32,
   parameter int MAX_SKIP   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [4:0] skip, [20:5] port, [23:21] zero
   input  logic [0:0]  req_tuser,   // [0] mode
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] granted_port, [31:16] used_count
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int LAST_BITS  = SLOT_COUNT - (WORD_COUNT - 1) * WORD_BITS;
   localparam int NORM_W     = $clog2(WORD_BITS + MAX_SKIP);
   localparam int RST_SLOT   = npba_pkg::PORT_BASE % SLOT_COUNT;
   localparam int RST_WORD   = RST_SLOT / WORD_BITS;
   localparam int RST_BIT    = RST_SLOT % WORD_BITS;
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORD_COUNT - 1);

   localparam int PW = npba_pkg::PORT_W;
   localparam int CW = npba_pkg::COUNT_W;

   npba_pkg::state_type  state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]    norm_word_ff, norm_word_in;
   logic [NORM_W-1:0]    norm_bit_ff, norm_bit_in;
   logic                 first_ff, first_in;
   logic [BIT_W-1:0]     free_bit_ff, free_bit_in;
   logic [ADDR_W-1:0]    cur_word_ff, cur_word_in;
   logic [BIT_W-1:0]     cur_bit_ff, cur_bit_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [PW-1:0]        res_grant_ff, res_grant_in;
   npba_pkg::status_type res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]        rsp_grant_ff, rsp_grant_in;
   npba_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;

   // Request fields
   logic [npba_pkg::SKIP_W-1:0] req_skip;
   logic [PW-1:0]               req_port;
   npba_pkg::op_type            req_mode;
   logic                        req_fire;

   // Memory port
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   // Helpers
   logic                 div_start;
   logic                 div_done;
   logic [ADDR_W-1:0]    div_word;
   logic [BIT_W-1:0]     div_bit;
   logic                 fnd_found;
   logic [BIT_W-1:0]     fnd_index;
   logic [8:0]           skip_eff;
   logic [PW-1:0]        free_slot;
   logic                 port_ok;
   logic [15:0]          norm_limit;
   logic [ADDR_W-1:0]    word_next;
   logic [31:0]          grant_sum;
   logic                 out_free;

   assign req_skip = req_tdata[4:0];
   assign req_port = req_tdata[20:5];
   assign req_mode = npba_pkg::op_type'(req_tuser[0]);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   npba_bitmap_ram #(
      .DEPTH  (WORD_COUNT),
      .WIDTH  (WORD_BITS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   npba_slot_split #(
      .WORD_BITS (WORD_BITS),
      .BIT_W     (BIT_W),
      .ADDR_W    (ADDR_W)
   ) u_split (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .slot    (free_slot),
      .done    (div_done),
      .word    (div_word),
      .bit_pos (div_bit)
   );

   npba_free_finder #(
      .WORD_BITS (WORD_BITS),
      .BIT_W     (BIT_W),
      .LAST_BITS (LAST_BITS)
   ) u_finder (
      .word_data (rd_data),
      .start_bit (norm_bit_ff[BIT_W-1:0]),
      .first     (first_ff),
      .last_word (norm_word_ff == LAST_WORD),
      .found     (fnd_found),
      .index     (fnd_index)
   );

   // Saturate skip, check the port of a free, size the current word
   always_comb begin
      skip_eff   = (9'(req_skip) > 9'(MAX_SKIP)) ? 9'(MAX_SKIP) : 9'(req_skip);
      free_slot  = req_port - PW'(npba_pkg::PORT_BASE);
      port_ok    = (req_port >= PW'(npba_pkg::PORT_BASE)) &&
                   (32'(free_slot) < 32'(SLOT_COUNT));
      norm_limit = (norm_word_ff == LAST_WORD) ? 16'(LAST_BITS) : 16'(WORD_BITS);
      word_next  = (norm_word_ff == LAST_WORD) ? '0 : norm_word_ff + ADDR_W'(1);
      grant_sum  = 32'(cur_word_ff) * 32'(WORD_BITS) + 32'(cur_bit_ff) +
                   32'(npba_pkg::PORT_BASE);
   end

   // Next state and register values
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      norm_word_in  = norm_word_ff;
      norm_bit_in   = norm_bit_ff;
      first_in      = first_ff;
      free_bit_in   = free_bit_ff;
      cur_word_in   = cur_word_ff;
      cur_bit_in    = cur_bit_ff;
      count_in      = count_ff;
      res_grant_in  = res_grant_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_grant_in  = rsp_grant_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = norm_word_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = norm_word_ff;
      div_start     = 1'b0;

      case (state_ff)
         // Sweep the bitmap to zero after reset
         npba_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_WORD) begin
               state_in = npba_pkg::S_IDLE;
            end
         end

         // Take a request transaction and dispatch it
         npba_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               res_grant_in = '0;
               if (req_mode == npba_pkg::OP_ALLOC) begin
                  if (32'(count_ff) >= 32'(SLOT_COUNT)) begin
                     res_status_in = npba_pkg::ST_FULL;
                     state_in      = npba_pkg::S_FINISH;
                  end else begin
                     norm_word_in = cur_word_ff;
                     norm_bit_in  = NORM_W'(16'(cur_bit_ff) + 16'(skip_eff));
                     state_in     = npba_pkg::S_NORM;
                  end
               end else if (!port_ok) begin
                  res_status_in = npba_pkg::ST_BAD_FREE;
                  state_in      = npba_pkg::S_FINISH;
               end else begin
                  div_start = 1'b1;
                  state_in  = npba_pkg::S_DIV;
               end
            end
         end

         // Carry the advanced cursor across word boundaries, then read its word
         npba_pkg::S_NORM: begin
            if (16'(norm_bit_ff) >= norm_limit) begin
               norm_bit_in  = NORM_W'(16'(norm_bit_ff) - norm_limit);
               norm_word_in = word_next;
            end else begin
               rd_en    = 1'b1;
               first_in = 1'b1;
               state_in = npba_pkg::S_SCAN;
            end
         end

         // Test one word a cycle; claim the first free bit
         npba_pkg::S_SCAN: begin
            if (fnd_found) begin
               wr_en       = 1'b1;
               wr_data     = rd_data | (WORD_BITS'(1) << fnd_index);
               cur_word_in = norm_word_ff;
               cur_bit_in  = fnd_index;
               count_in    = count_ff + CW'(1);
               state_in    = npba_pkg::S_GRANT;
            end else begin
               norm_word_in = word_next;
               rd_en        = 1'b1;
               rd_addr      = word_next;
               first_in     = 1'b0;
            end
         end

         // Turn the claimed slot into a port number
         npba_pkg::S_GRANT: begin
            res_grant_in  = grant_sum[PW-1:0];
            res_status_in = npba_pkg::ST_OK;
            state_in      = npba_pkg::S_FINISH;
         end

         // Wait for the word/bit split, then read the word
         npba_pkg::S_DIV: begin
            if (div_done) begin
               norm_word_in = div_word;
               free_bit_in  = div_bit;
               rd_en        = 1'b1;
               rd_addr      = div_word;
               state_in     = npba_pkg::S_FREE_CHK;
            end
         end

         // Release the slot if it is in use, else flag the free
         npba_pkg::S_FREE_CHK: begin
            if (rd_data[free_bit_ff]) begin
               wr_en         = 1'b1;
               wr_data       = rd_data & ~(WORD_BITS'(1) << free_bit_ff);
               res_status_in = npba_pkg::ST_OK;
               if (count_ff != '0) begin
                  count_in = count_ff - CW'(1);
               end
            end else begin
               res_status_in = npba_pkg::ST_BAD_FREE;
            end
            state_in = npba_pkg::S_FINISH;
         end

         // Load the output register once it is free
         npba_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_grant_in  = res_grant_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               state_in      = npba_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = npba_pkg::S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npba_pkg::S_CLEAR;
         clr_ff       <= '0;
         cur_word_ff  <= ADDR_W'(RST_WORD);
         cur_bit_ff   <= BIT_W'(RST_BIT);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_word_ff  <= cur_word_in;
         cur_bit_ff   <= cur_bit_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      norm_word_ff  <= norm_word_in;
      norm_bit_ff   <= norm_bit_in;
      first_ff      <= first_in;
      free_bit_ff   <= free_bit_in;
      res_grant_ff  <= res_grant_in;
      res_status_ff <= res_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_grant_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
